[sv/assert_macros.svh]
// Assertion macros for the RTL files that check themselves; the top level uses them.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_CHK(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");

`endif

[sv/fnps_pkg.sv]
// Shared types and constants of the noisy Fenwick prefix-sum block.
// No dependencies; imported by the controller, the datapath and the top level.
`default_nettype none

package fnps_pkg;

	localparam logic [1:0] OP_NOISE   = 2'd0;
	localparam logic [1:0] OP_DATA    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	localparam int OPCODE_W   = 2;
	localparam int NODE_IN_W  = 11;
	localparam int DIM_IN_W   = 2;
	localparam int VALUE_W    = 64;
	localparam int STEP_OUT_W = 10;
	localparam int DIM_OUT_W  = 2;

	localparam int IN_USED_W   = NODE_IN_W + DIM_IN_W + VALUE_W;
	localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
	localparam int OUT_USED_W  = VALUE_W + STEP_OUT_W + DIM_OUT_W;
	localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

	typedef struct packed {
		logic noise_we;
		logic data_start;
		logic restart;
		logic clr_step;
		logic upd_wr;
		logic qry_issue;
		logic out_load;
	} fnps_cmd_t;

	typedef struct packed {
		logic overrun;
		logic clr_last;
		logic upd_more;
		logic qry_more;
		logic out_busy;
	} fnps_sts_t;

endpackage

`default_nettype wire

[sv/fnps_ctrl.sv]
// Controller of the noisy Fenwick prefix-sum block: input decode and walk sequencing.
// Depends on fnps_pkg for opcodes and the command/status structs.
`default_nettype none

module fnps_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	input  wire logic [fnps_pkg::OPCODE_W-1:0] opcode,
	input  wire fnps_pkg::fnps_sts_t         sts,
	output logic                             s_tready,
	output fnps_pkg::fnps_cmd_t              cmd
);
	import fnps_pkg::*;

	localparam logic [2:0] S_CLEAR   = 3'd0;
	localparam logic [2:0] S_IDLE    = 3'd1;
	localparam logic [2:0] S_UPD_RD  = 3'd2;
	localparam logic [2:0] S_UPD_WR  = 3'd3;
	localparam logic [2:0] S_QRY     = 3'd4;
	localparam logic [2:0] S_QRY_END = 3'd5;
	localparam logic [2:0] S_DONE    = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = (state_q == S_IDLE);
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					unique case (opcode)
						OP_NOISE: begin
							cmd.noise_we = 1'b1;
						end
						OP_DATA: begin
							cmd.data_start = 1'b1;
							// overrun skips the walks and reports at once
							state_d = sts.overrun ? S_DONE : S_UPD_RD;
						end
						OP_RESTART: begin
							cmd.restart = 1'b1;
							state_d     = S_CLEAR;
						end
						OP_NONE: begin
							state_d = S_IDLE;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_UPD_RD: begin
				state_d = S_UPD_WR;
			end
			S_UPD_WR: begin
				cmd.upd_wr = 1'b1;
				state_d    = sts.upd_more ? S_UPD_RD : S_QRY;
			end
			S_QRY: begin
				cmd.qry_issue = 1'b1;
				if (!sts.qry_more) begin
					state_d = S_QRY_END;
				end
			end
			S_QRY_END: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				// hold the result until the output register frees up
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[sv/fnps_dp.sv]
// Datapath of the noisy Fenwick prefix-sum block: tree and noise memories,
// walk index, accumulator, step counters and output register. Uses fnps_pkg.
`default_nettype none

module fnps_dp #(
	parameter int STEPS = 1024,
	parameter int DIMS  = 4,
	parameter int HOPS  = 11
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire fnps_pkg::fnps_cmd_t                  cmd,
	output fnps_pkg::fnps_sts_t                       sts,
	input  wire logic [fnps_pkg::NODE_IN_W-1:0]       node,
	input  wire logic [fnps_pkg::DIM_IN_W-1:0]        dim,
	input  wire logic signed [fnps_pkg::VALUE_W-1:0]  value,
	input  wire logic                                 m_tready,
	output logic                                      m_tvalid,
	output logic signed [fnps_pkg::VALUE_W-1:0]       prefix_sum,
	output logic [fnps_pkg::STEP_OUT_W-1:0]           step_index,
	output logic [fnps_pkg::DIM_OUT_W-1:0]            dim_index,
	output logic                                      status
);
	import fnps_pkg::*;

	localparam int DIM_W   = (DIMS > 1) ? $clog2(DIMS) : 1;
	localparam int NODE_AW = $clog2(STEPS);
	localparam int ADDR_W  = NODE_AW + DIM_W;
	localparam int DEPTH   = 1 << ADDR_W;
	localparam int STEP_W  = $clog2(STEPS + 1);
	localparam int IDX_W   = STEP_W + 1;
	localparam int HOP_W   = $clog2(HOPS + 1);

	logic [STEP_W-1:0]         step_q;
	logic [DIM_W-1:0]          dim_q;
	logic [IDX_W-1:0]          idx_q;
	logic [HOP_W-1:0]          hop_q;
	logic [ADDR_W-1:0]         clr_q;
	logic                      ovr_q;
	logic                      qv_s1;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic signed [VALUE_W-1:0] acc_q;
	logic signed [VALUE_W-1:0] tree_rd_q;
	logic signed [VALUE_W-1:0] noise_rd_q;

	logic signed [VALUE_W-1:0] tree_mem  [DEPTH];
	logic signed [VALUE_W-1:0] noise_mem [DEPTH];

	logic [IDX_W-1:0]          idx_low;
	logic [IDX_W-1:0]          idx_up;
	logic [IDX_W-1:0]          idx_dn;
	logic [IDX_W-1:0]          start_idx;
	logic                      hop_last;
	logic [ADDR_W-1:0]         walk_addr;
	logic [ADDR_W-1:0]         load_addr;
	logic                      noise_ok;
	logic                      tree_we;
	logic [ADDR_W-1:0]         tree_addr;
	logic signed [VALUE_W-1:0] tree_wd;
	logic [ADDR_W-1:0]         noise_addr;
	logic                      last_dim;

	assign idx_low   = idx_q & (~idx_q + IDX_W'(1));
	assign idx_up    = idx_q + idx_low;
	assign idx_dn    = idx_q - idx_low;
	assign start_idx = IDX_W'(step_q) + IDX_W'(1);
	assign hop_last  = (32'(hop_q) + 32'd1) >= 32'(HOPS);
	assign walk_addr = {NODE_AW'(idx_q - IDX_W'(1)), dim_q};
	assign load_addr = {NODE_AW'(node - NODE_IN_W'(1)), DIM_W'(dim)};
	assign noise_ok  = (node != '0) && (32'(node) <= 32'(STEPS)) && (32'(dim) < 32'(DIMS));
	assign last_dim  = 32'(dim_q) == 32'(DIMS - 1);

	assign sts.overrun  = 32'(step_q) >= 32'(STEPS);
	assign sts.clr_last = &clr_q;
	assign sts.upd_more = !hop_last && (32'(idx_up) <= 32'(STEPS));
	assign sts.qry_more = !hop_last && (idx_dn != '0);
	assign sts.out_busy = out_valid_q && !m_tready;

	assign tree_we    = cmd.clr_step || cmd.upd_wr;
	assign tree_addr  = cmd.clr_step ? clr_q : walk_addr;
	assign tree_wd    = cmd.clr_step ? '0 : (tree_rd_q + value_q);
	assign noise_addr = cmd.noise_we ? load_addr : walk_addr;

	always_ff @(posedge clk) begin
		if (tree_we) begin
			tree_mem[tree_addr] <= tree_wd;
		end
		tree_rd_q <= tree_mem[tree_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.noise_we && noise_ok) begin
			noise_mem[noise_addr] <= value;
		end
		noise_rd_q <= noise_mem[noise_addr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			dim_q       <= '0;
			idx_q       <= '0;
			hop_q       <= '0;
			clr_q       <= '0;
			ovr_q       <= 1'b0;
			qv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			qv_s1 <= cmd.qry_issue;
			if (cmd.restart) begin
				step_q <= '0;
				dim_q  <= '0;
				clr_q  <= '0;
			end else if (cmd.clr_step) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (cmd.data_start) begin
				ovr_q <= sts.overrun;
				idx_q <= start_idx;
				hop_q <= '0;
			end else if (cmd.upd_wr) begin
				if (sts.upd_more) begin
					idx_q <= idx_up;
					hop_q <= hop_q + HOP_W'(1);
				end else begin
					// rewind to the query start node
					idx_q <= start_idx;
					hop_q <= '0;
				end
			end else if (cmd.qry_issue) begin
				idx_q <= idx_dn;
				hop_q <= hop_q + HOP_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				if (!ovr_q) begin
					if (last_dim) begin
						dim_q  <= '0;
						step_q <= step_q + STEP_W'(1);
					end else begin
						dim_q <= dim_q + DIM_W'(1);
					end
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.data_start) begin
			value_q <= value;
		end
		if (cmd.data_start || (cmd.upd_wr && !sts.upd_more)) begin
			acc_q <= '0;
		end else if (qv_s1) begin
			acc_q <= acc_q + tree_rd_q + noise_rd_q;
		end
		if (cmd.out_load) begin
			prefix_sum <= ovr_q ? '0 : acc_q;
			step_index <= ovr_q ? '0 : STEP_OUT_W'(step_q);
			dim_index  <= ovr_q ? '0 : DIM_OUT_W'(dim_q);
			status     <= ovr_q;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

[sv/fenwick_noisy_prefix_sum.sv]
// Top level of the noisy Fenwick prefix-sum block; joins fnps_ctrl and fnps_dp.
// Depends on fnps_pkg and assert_macros.svh.
// Input stream: s_tuser carries the opcode (load noise word, data sample, restart).
// Each data sample is added along its Fenwick update path, then the query path
// is summed (tree sum plus noise per node) and one result leaves on m_*.
// A sample walks U update hops, then Q query hops (each at most HOPS); every
// update hop is a read then a write on the single tree memory port, every query
// hop one read whose tree and noise words are added to the accumulator. After
// the walks the result is loaded into the output register, which drives m_tvalid.
// With the defaults the longest walk is node 1 (11 update hops, 1 query hop).
// Overrun samples skip the walks and go straight to the output register.
// Noise loads and the unused opcode are taken without leaving the idle state.
// One item is in work at a time; s_tready drops until its result is registered.
// A finished result waits in the output register while the next item is taken;
// if the receiver stalls longer, the block holds in its last step.
// Reset and restart run a clearing pass, one entry a cycle, over all
// 2^(clog2(STEPS)+clog2(DIMS)) tree memory entries (4096 by default), with s_tready low.
// A sample after the last step returns status 1 with all data zero.
`default_nettype none
`include "assert_macros.svh"

module fenwick_noisy_prefix_sum #(
	parameter int STEPS = 1024,
	parameter int DIMS  = 4,
	parameter int HOPS  = 11
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// node [10:0], dim [12:11], value [76:13], zero [79:77]
	input  wire logic [fnps_pkg::IN_DATA_W-1:0]    s_tdata,
	// opcode [1:0]
	input  wire logic [fnps_pkg::OPCODE_W-1:0]     s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// prefix_sum [63:0], step_index [73:64], dim_index [75:74], zero [79:76]
	output logic [fnps_pkg::OUT_DATA_W-1:0]        m_tdata,
	// status [0]
	output logic                                   m_tuser
);
	import fnps_pkg::*;

	localparam int DIM_LO   = NODE_IN_W;
	localparam int VALUE_LO = NODE_IN_W + DIM_IN_W;

	fnps_cmd_t cmd;
	fnps_sts_t sts;

	logic signed [VALUE_W-1:0] prefix_sum;
	logic [STEP_OUT_W-1:0]     step_index;
	logic [DIM_OUT_W-1:0]      dim_index;
	logic                      status;

	fnps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.opcode   (s_tuser),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	fnps_dp #(
		.STEPS (STEPS),
		.DIMS  (DIMS),
		.HOPS  (HOPS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.node       (s_tdata[NODE_IN_W-1:0]),
		.dim        (s_tdata[DIM_LO +: DIM_IN_W]),
		.value      (s_tdata[VALUE_LO +: VALUE_W]),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.prefix_sum (prefix_sum),
		.step_index (step_index),
		.dim_index  (dim_index),
		.status     (status)
	);

	assign m_tdata = {(OUT_DATA_W - OUT_USED_W)'(0), dim_index, step_index, prefix_sum};
	assign m_tuser = status;

	`ASSERT_NEVER(a_no_walk_when_ready, clk, arst_n, s_tready && (cmd.upd_wr || cmd.qry_issue))
	`ASSERT_CHK(a_overrun_zero, clk, arst_n, (m_tvalid && m_tuser) |-> (m_tdata == '0))
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.out_load && m_tvalid && !m_tready)
	`ASSERT_CHK(a_restart_clears, clk, arst_n, (s_tvalid && s_tready && (s_tuser == OP_RESTART)) |=> !s_tready)

endmodule

`default_nettype wire
